// ===== design/bprt_pkg.sv =====
// Package for the BPDU root tracker and TC notification unit.
// Holds the queue entry type, item kinds and field constants; no dependencies.
package bprt_pkg;

    localparam int unsigned SDataW   = 160;
    localparam int unsigned SUserW   = 2;
    localparam int unsigned MDataW   = 8;
    localparam int unsigned RootW    = 64;
    localparam int unsigned HoldW    = 5;
    localparam int unsigned CountW   = 5;
    localparam int unsigned LimitW   = 4;
    localparam int unsigned QDepth   = 2;
    localparam int unsigned QPtrW    = 1;
    localparam int unsigned QCountW  = 2;

    localparam logic [1:0]  CMD_BPDU  = 2'd0;
    localparam logic [1:0]  CMD_TICK  = 2'd1;
    localparam logic [1:0]  CMD_START = 2'd2;

    localparam logic [10:0] LEN_COMMON = 11'd4;
    localparam logic [10:0] LEN_CONF   = 11'd35;
    localparam logic [10:0] LEN_RCONF  = 11'd36;

    localparam logic [7:0]  TYPE_CONF  = 8'h00;
    localparam logic [7:0]  TYPE_RCONF = 8'h02;
    localparam logic [7:0]  TYPE_TCN   = 8'h80;

    localparam logic [7:0]  HELLO_MAX      = 8'd10;
    localparam logic [LimitW-1:0] TC_LIMIT_RESET = 4'd5;

    typedef enum logic [2:0] {
        KIND_NOP   = 3'd0,
        KIND_WARN  = 3'd1,
        KIND_BPDU  = 3'd2,
        KIND_TICK  = 3'd3,
        KIND_START = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [RootW-1:0]  root_id;
        logic [HoldW-1:0]  hold;
        logic              tc_flag;
    } qent_t;

endpackage

// ===== design/bprt_front.sv =====
// Front end: accepts input words and classifies them into queue entries.
// Depends on bprt_pkg; stateless apart from the handshake with the queue.
module bprt_front import bprt_pkg::*; (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [SDataW-1:0] s_tdata,
    input  logic [SUserW-1:0] s_tuser,
    input  logic              q_full,
    output logic              q_push,
    output qent_t             q_entry
);

    logic [10:0] frame_length;
    logic [15:0] protocol_id;
    logic [7:0]  bpdu_type;
    logic [7:0]  bpdu_flags;
    logic [15:0] message_age;
    logic [15:0] max_age;
    logic [15:0] hello_time;
    logic [7:0]  hello_sec;
    logic [3:0]  hello_clamped;
    kind_t       kind;

    assign frame_length = s_tdata[10:0];
    assign protocol_id  = s_tdata[26:11];
    assign bpdu_type    = s_tdata[34:27];
    assign bpdu_flags   = s_tdata[42:35];
    assign message_age  = s_tdata[122:107];
    assign max_age      = s_tdata[138:123];
    assign hello_time   = s_tdata[154:139];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // clamp hello time to 1..10 whole seconds
    assign hello_sec = hello_time[15:8];
    always_comb begin
        if (hello_sec == 8'd0) begin
            hello_clamped = 4'd1;
        end else if (hello_sec > HELLO_MAX) begin
            hello_clamped = HELLO_MAX[3:0];
        end else begin
            hello_clamped = hello_sec[3:0];
        end
    end

    always_comb begin
        case (s_tuser)
            CMD_BPDU: begin
                if (frame_length < LEN_COMMON) begin
                    kind = KIND_WARN;
                end else if (protocol_id != 16'd0) begin
                    kind = KIND_NOP;
                end else if (bpdu_type == TYPE_CONF) begin
                    if (frame_length < LEN_CONF || message_age >= max_age) begin
                        kind = KIND_WARN;
                    end else begin
                        kind = KIND_BPDU;
                    end
                end else if (bpdu_type == TYPE_RCONF) begin
                    kind = (frame_length < LEN_RCONF) ? KIND_WARN : KIND_BPDU;
                end else if (bpdu_type == TYPE_TCN) begin
                    kind = KIND_NOP;
                end else begin
                    kind = KIND_WARN;
                end
            end
            CMD_TICK:  kind = KIND_TICK;
            CMD_START: kind = KIND_START;
            default:   kind = KIND_NOP;
        endcase
    end

    always_comb begin
        q_entry.kind    = kind;
        q_entry.root_id = s_tdata[106:43];
        q_entry.hold    = {hello_clamped, 1'b0} + {1'b0, hello_clamped};
        q_entry.tc_flag = bpdu_flags[0];
    end

endmodule

// ===== design/bprt_queue.sv =====
// Short queue of classified entries between front and back ends.
// Depends on bprt_pkg for the entry type and depth.
module bprt_queue import bprt_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  qent_t push_entry,
    input  logic  pop,
    output logic  full,
    output logic  empty,
    output qent_t head
);

    qent_t              mem_reg [QDepth];
    logic [QPtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCountW-1:0] count_reg, count_next;

    assign full  = (count_reg == QCountW'(QDepth));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCountW'(push) - QCountW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== design/bprt_back.sv =====
// Back end: applies queue entries to the root and TC state, drives the result word.
// Depends on bprt_pkg; holds the configuration register.
module bprt_back import bprt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [LimitW-1:0] cfg_wr_data,
    input  logic              q_empty,
    input  qent_t             q_head,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [MDataW-1:0] m_tdata
);

    logic [RootW-1:0]  stored_root_reg, stored_root_next;
    logic              root_held_reg, root_held_next;
    logic [HoldW-1:0]  hold_reg, hold_next;
    logic [CountW-1:0] tc_cnt_reg, tc_cnt_next;
    logic [CountW-1:0] tc_cnt_inc;
    logic [LimitW-1:0] limit_reg;
    logic              out_valid_reg;
    logic [MDataW-1:0] out_data_reg, out_data_next;
    logic              status, accepted, inhibit, cancelled, send_tc;

    assign q_pop    = !q_empty && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign tc_cnt_inc = tc_cnt_reg + 1'b1;

    always_comb begin
        stored_root_next = stored_root_reg;
        root_held_next   = root_held_reg;
        hold_next        = hold_reg;
        tc_cnt_next      = tc_cnt_reg;
        status           = 1'b0;
        accepted         = 1'b0;
        inhibit          = 1'b0;
        cancelled        = 1'b0;
        send_tc          = 1'b0;
        case (q_head.kind)
            KIND_WARN: status = 1'b1;
            KIND_BPDU: begin
                // drop a worse root while one is held
                if (!root_held_reg || q_head.root_id <= stored_root_reg) begin
                    accepted         = 1'b1;
                    inhibit          = (q_head.root_id != stored_root_reg);
                    stored_root_next = q_head.root_id;
                    root_held_next   = 1'b1;
                    hold_next        = q_head.hold;
                    if (q_head.tc_flag && tc_cnt_reg != '0) begin
                        cancelled   = 1'b1;
                        tc_cnt_next = '0;
                    end
                end
            end
            KIND_TICK: begin
                if (root_held_reg) begin
                    if (hold_reg == '0) begin
                        root_held_next = 1'b0;
                    end else begin
                        hold_next = hold_reg - 1'b1;
                    end
                end
                if (tc_cnt_reg != '0) begin
                    send_tc     = 1'b1;
                    tc_cnt_next = (tc_cnt_inc > {1'b0, limit_reg}) ? '0 : tc_cnt_inc;
                end
            end
            KIND_START: tc_cnt_next = CountW'(1);
            default: ;
        endcase
        out_data_next = {3'b000, send_tc, cancelled, inhibit, accepted, status};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_root_reg <= '0;
            root_held_reg   <= 1'b0;
            hold_reg        <= '0;
            tc_cnt_reg      <= '0;
            limit_reg       <= TC_LIMIT_RESET;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (q_pop) begin
                stored_root_reg <= stored_root_next;
                root_held_reg   <= root_held_next;
                hold_reg        <= hold_next;
                tc_cnt_reg      <= tc_cnt_next;
                out_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== design/bpdu_root_tracker_tc_notify_unit.sv =====
// Top level of the BPDU root tracker and TC notification unit.
// Depends on bprt_pkg, bprt_front, bprt_queue and bprt_back.
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid/s_tready    s_tuser command, s_tdata header fields
//  m_        out        m_tvalid/m_tready    m_tdata result flags
//  cfg_      in         cfg_wr_en            cfg_wr_data tc_repeat_limit
//
// One input word per cycle while s_tready is high; the accepting edge writes the
// queue, and a pop of the queue head loads the output register, which offers the
// result word. In steady flow the queue holds one word, so an output stall fills
// it and drops s_tready until the output moves.
// aresetn is synchronous, active low; it clears root, hold and TC state and
// sets the repeat limit to 5.
module bpdu_root_tracker_tc_notify_unit import bprt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // [10:0] frame_length, [26:11] protocol_id, [34:27] bpdu_type,
    // [42:35] bpdu_flags, [106:43] root_id, [122:107] message_age,
    // [138:123] max_age, [154:139] hello_time, [159:155] zero
    input  logic [SDataW-1:0] s_tdata,
    // [1:0] command
    input  logic [SUserW-1:0] s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // [0] status, [1] root_accepted, [2] inhibit, [3] tc_cancelled,
    // [4] send_tc, [7:5] zero
    output logic [MDataW-1:0] m_tdata,
    input  logic              cfg_wr_en,
    input  logic [LimitW-1:0] cfg_wr_data
);

    logic  q_push, q_pop, q_full, q_empty;
    qent_t q_in, q_head;

    bprt_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    bprt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (q_head)
    );

    bprt_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

`ifndef SYNTH
    a_inhibit_needs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> m_tdata[1])
        else $error("inhibit without root acceptance");

    a_cancel_needs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[1])
        else $error("TC cancel without root acceptance");

    a_warn_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[4:1] == 4'd0)
        else $error("warning result carries other flags");

    a_queue_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full && !q_pop |=> !s_tready)
        else $error("queue full but input still ready");
`endif

endmodule
